FILE: rtl/assert_macros.svh
// assertion macros used by axis_homing_sequencer_core
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// antecedent in this cycle implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent in this cycle implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ahs_pkg.sv
// types, codes and command helper for the axis homing sequencer
// no dependencies
`default_nettype none

package ahs_pkg;

    localparam int AXIS_COUNT_DEF = 3;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_STOPPED = 3'd1;
    localparam logic [2:0] OP_CLOSED  = 3'd2;
    localparam logic [2:0] OP_OPENED  = 3'd3;

    localparam logic [2:0] PH_LOST        = 3'd0;
    localparam logic [2:0] PH_STOPPING    = 3'd1;
    localparam logic [2:0] PH_CLOSING     = 3'd2;
    localparam logic [2:0] PH_CLOSED_WAIT = 3'd3;
    localparam logic [2:0] PH_OPENING     = 3'd4;
    localparam logic [2:0] PH_OPENED_WAIT = 3'd5;
    localparam logic [2:0] PH_OFFSETTING  = 3'd6;
    localparam logic [2:0] PH_FOUND       = 3'd7;

    localparam logic [2:0] K_STARTED   = 3'd0;
    localparam logic [2:0] K_ERROR     = 3'd1;
    localparam logic [2:0] K_COMPLETED = 3'd2;
    localparam logic [2:0] K_STOP      = 3'd3;
    localparam logic [2:0] K_MOVE      = 3'd4;

    localparam logic [1:0] CFG_AXIS_ORDER = 2'd0;
    localparam logic [1:0] CFG_TOWARD_MAX = 2'd1;
    localparam logic [1:0] CFG_MAX_SWITCH = 2'd2;
    localparam logic [1:0] CFG_MIN_SWITCH = 2'd3;

    localparam logic [5:0] AXIS_ORDER_RST = 6'd18;
    localparam logic [2:0] TOWARD_MAX_RST = 3'd7;
    localparam logic [2:0] MAX_SWITCH_RST = 3'd7;
    localparam logic [2:0] MIN_SWITCH_RST = 3'd0;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] switch_axis;
        logic       switch_at_max;
        logic [5:0] switch_levels;
        logic       motion_running;
    } evt_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [1:0] move_axis;
        logic       move_positive;
        logic       slow_speed;
        logic       offset_distance;
        logic [2:0] homing_phase;
        logic       last;
    } cmd_t;

    // pending command without the fields filled in at output time
    typedef struct packed {
        logic [2:0] kind;
        logic       move_positive;
        logic       slow_speed;
        logic       offset_distance;
    } pend_t;

    function automatic pend_t enter_cmd(input logic [2:0] ph, input logic tmax);
        pend_t c;
        c = '{kind: K_STOP, move_positive: 1'b0, slow_speed: 1'b0,
              offset_distance: 1'b0};
        case (ph)
            PH_CLOSING:
            begin
                c.kind          = K_MOVE;
                c.move_positive = tmax;
            end
            PH_OPENING:
            begin
                c.kind          = K_MOVE;
                c.move_positive = ~tmax;
                c.slow_speed    = 1'b1;
            end
            PH_OFFSETTING:
            begin
                c.kind            = K_MOVE;
                c.move_positive   = ~tmax;
                c.offset_distance = 1'b1;
            end
            PH_FOUND:
            begin
                c.kind = K_COMPLETED;
            end
            default:
            begin
                c.kind = K_STOP;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/axis_homing_sequencer_core.sv
// axis homing sequencer: event-driven homing of up to three axes
// a phase-changing non-start event gives its command in the cycle after acceptance
// start and next-axis steps scan one order slot per cycle to a usable axis or the end
// up to two commands per transaction; ready again once the last one is taken
// async active-low reset: phase lost, slot and axis zero, registers at defaults
// depends on ahs_pkg and assert_macros.svh
`default_nettype none

module axis_homing_sequencer_core #(
    parameter int AXIS_COUNT = ahs_pkg::AXIS_COUNT_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          evt_valid,
    output logic               evt_ready,
    input  wire ahs_pkg::evt_t evt,
    output logic               cmd_valid,
    input  wire logic          cmd_ready,
    output ahs_pkg::cmd_t      cmd,
    input  wire logic          cfg_we,
    input  wire logic [1:0]    cfg_index,
    input  wire logic [5:0]    cfg_data
);
    import ahs_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] AXIS_LIMIT = 3'(AXIS_COUNT);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_OUT0 = 2'd2;
    localparam logic [1:0] ST_OUT1 = 2'd3;

    logic [5:0] axis_order_reg;
    logic [2:0] toward_max_reg;
    logic [2:0] max_switch_reg;
    logic [2:0] min_switch_reg;

    logic [1:0] state_reg, state_next;
    logic [2:0] phase_reg, phase_next;
    logic [1:0] slot_reg, slot_next;
    logic [1:0] axis_reg, axis_next;
    logic       side_reg, side_next;
    logic       start_reg, start_next;
    logic       two_reg, two_next;
    evt_t       evt_reg, evt_next;
    pend_t      r0_reg, r0_next;
    pend_t      r1_reg, r1_next;

    logic [3:0] tmx4, max4, min4;
    logic [7:0] order8, lv_in8, lv_reg8;
    logic [1:0] cand;
    logic       cand_tmax, cand_usable;
    logic       cur_tmax, sw_match, slot_open;
    logic [2:0] np;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_order_reg <= AXIS_ORDER_RST;
            toward_max_reg <= TOWARD_MAX_RST;
            max_switch_reg <= MAX_SWITCH_RST;
            min_switch_reg <= MIN_SWITCH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AXIS_ORDER: axis_order_reg <= cfg_data;
                CFG_TOWARD_MAX: toward_max_reg <= cfg_data[2:0];
                CFG_MAX_SWITCH: max_switch_reg <= cfg_data[2:0];
                CFG_MIN_SWITCH: min_switch_reg <= cfg_data[2:0];
                default:        axis_order_reg <= axis_order_reg;
            endcase
        end
    end

    assign tmx4    = {1'b0, toward_max_reg};
    assign max4    = {1'b0, max_switch_reg};
    assign min4    = {1'b0, min_switch_reg};
    assign order8  = {2'b00, axis_order_reg};
    assign lv_in8  = {2'b00, evt.switch_levels};
    assign lv_reg8 = {2'b00, evt_reg.switch_levels};

    // slot scan unit
    assign cand        = order8[{slot_reg, 1'b0} +: 2];
    assign cand_tmax   = tmx4[cand];
    assign cand_usable = ({1'b0, cand} < AXIS_LIMIT) && (cand_tmax ? max4[cand] : min4[cand]);
    assign slot_open   = {1'b0, slot_reg} < AXIS_LIMIT;

    assign cur_tmax = tmx4[axis_reg];
    assign sw_match = (evt.switch_axis == axis_reg) && (evt.switch_at_max == side_reg);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        slot_next  = slot_reg;
        axis_next  = axis_reg;
        side_next  = side_reg;
        start_next = start_reg;
        two_next   = two_reg;
        evt_next   = evt_reg;
        r0_next    = r0_reg;
        r1_next    = r1_reg;
        np         = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (evt_valid)
                begin
                    evt_next = evt;
                    two_next = 1'b0;
                    if (evt.op == OP_START)
                    begin
                        slot_next  = 2'd0;
                        start_next = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_STOPPING:
                                if (evt.op == OP_STOPPED)
                                    np = lv_in8[{axis_reg, side_reg}] ? PH_OPENING : PH_CLOSING;
                            PH_CLOSING:
                                if (evt.op == OP_CLOSED && sw_match)
                                    np = PH_CLOSED_WAIT;
                            PH_CLOSED_WAIT:
                                if (evt.op == OP_STOPPED)
                                    np = PH_OPENING;
                            PH_OPENING:
                                if (evt.op == OP_OPENED && sw_match)
                                    np = PH_OPENED_WAIT;
                            PH_OPENED_WAIT:
                                if (evt.op == OP_STOPPED)
                                    np = PH_OFFSETTING;
                            PH_OFFSETTING:
                                if (evt.op == OP_STOPPED)
                                begin
                                    if (slot_open)
                                    begin
                                        slot_next  = slot_reg + 2'd1;
                                        start_next = 1'b0;
                                        state_next = ST_SCAN;
                                    end
                                    else
                                    begin
                                        np = PH_FOUND;
                                    end
                                end
                            default:
                                np = phase_reg;
                        endcase
                        if (np != phase_reg)
                        begin
                            phase_next = np;
                            r0_next    = enter_cmd(np, cur_tmax);
                            state_next = ST_OUT0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (!slot_open)
                begin
                    state_next = ST_OUT0;
                    if (start_reg)
                    begin
                        r0_next = '{kind: K_ERROR, move_positive: 1'b0, slow_speed: 1'b0,
                                    offset_distance: 1'b0};
                    end
                    else
                    begin
                        phase_next = PH_FOUND;
                        r0_next    = enter_cmd(PH_FOUND, cur_tmax);
                    end
                end
                else if (cand_usable)
                begin
                    axis_next  = cand;
                    side_next  = cand_tmax;
                    state_next = ST_OUT0;
                    if (start_reg && evt_reg.motion_running)
                        np = PH_STOPPING;
                    else
                        np = lv_reg8[{cand, cand_tmax}] ? PH_OPENING : PH_CLOSING;
                    phase_next = np;
                    if (start_reg)
                    begin
                        r0_next  = '{kind: K_STARTED, move_positive: 1'b0, slow_speed: 1'b0,
                                     offset_distance: 1'b0};
                        r1_next  = enter_cmd(np, cand_tmax);
                        two_next = 1'b1;
                    end
                    else
                    begin
                        r0_next = enter_cmd(np, cand_tmax);
                    end
                end
                else
                begin
                    slot_next = slot_reg + 2'd1;
                end
            end
            ST_OUT0:
            begin
                if (cmd_ready)
                    state_next = two_reg ? ST_OUT1 : ST_IDLE;
            end
            ST_OUT1:
            begin
                if (cmd_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_LOST;
            slot_reg  <= 2'd0;
            axis_reg  <= 2'd0;
            side_reg  <= 1'b0;
            start_reg <= 1'b0;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            slot_reg  <= slot_next;
            axis_reg  <= axis_next;
            side_reg  <= side_next;
            start_reg <= start_next;
            two_reg   <= two_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        evt_reg <= evt_next;
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
    end

    pend_t cur;

    assign cur       = (state_reg == ST_OUT1) ? r1_reg : r0_reg;
    assign evt_ready = (state_reg == ST_IDLE);
    assign cmd_valid = (state_reg == ST_OUT0) || (state_reg == ST_OUT1);

    always_comb
    begin
        cmd.kind            = cur.kind;
        cmd.move_axis       = axis_reg;
        cmd.move_positive   = cur.move_positive;
        cmd.slow_speed      = cur.slow_speed;
        cmd.offset_distance = cur.offset_distance;
        cmd.homing_phase    = phase_reg;
        cmd.last            = (state_reg == ST_OUT1) || !two_reg;
    end

    `ASSERT_SAME(a_ready_excl, clk, rst_n, evt_ready, !cmd_valid)
    `ASSERT_ALWAYS(a_slot_range, clk, rst_n, {1'b0, slot_reg} <= AXIS_LIMIT)
    `ASSERT_SAME(a_out1_from_out0, clk, rst_n, state_reg == ST_OUT1, $past(state_reg == ST_OUT0 || state_reg == ST_OUT1))
    `ASSERT_NEXT(a_second_follows, clk, rst_n, cmd_valid && cmd_ready && !cmd.last,
                 cmd_valid && cmd.last)

endmodule

`default_nettype wire
